// File: rtl/core/slxd_pkg.sv
`timescale 1ns / 1ps
package slxd_pkg;

  localparam int STORE_BYTES = 64;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 7;

  typedef enum logic [2:0] {
    PH_SYNC1  = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_LENGTH = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_PACKET = 2'd1,
    ST_BADLEN = 2'd2,
    ST_BADSUM = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_MAX_LENGTH  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic             single;
    logic             start;
    status_t          status;
    logic [LEN_W-1:0] len;
  } evt_t;

endpackage

// File: rtl/core/slxd_ram.sv
`timescale 1ns / 1ps
module slxd_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/slxd_parser.sv
`timescale 1ns / 1ps
module slxd_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [7:0]                    cfg_wdata,
  input  logic                          in_fire,
  input  logic [slxd_pkg::BYTE_W-1:0]   in_byte,
  output slxd_pkg::evt_t                evt,
  output logic                          ram_we,
  output logic [slxd_pkg::ADDR_W-1:0]   ram_waddr,
  output logic [slxd_pkg::BYTE_W-1:0]   ram_wdata
);
  import slxd_pkg::*;

  logic [BYTE_W-1:0] sync1_r;
  logic [BYTE_W-1:0] sync2_r;
  logic [LEN_W-1:0]  max_len_r;

  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  flen_r, flen_nxt;
  logic [LEN_W-1:0]  bcnt_r, bcnt_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;

  logic [LEN_W-1:0]  limit;
  logic              len_bad;
  logic [LEN_W-1:0]  bcnt_inc;
  logic              sum_ok;

  assign limit    = (max_len_r < LEN_W'(STORE_BYTES)) ? max_len_r : LEN_W'(STORE_BYTES);
  assign len_bad  = (in_byte == '0) || (in_byte > {1'b0, limit});
  assign bcnt_inc = bcnt_r + LEN_W'(1);
  assign sum_ok   = (in_byte == xor_r) && (flen_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync1_r   <= 8'd170;
      sync2_r   <= 8'd85;
      max_len_r <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync1_r   <= cfg_wdata;
        CFG_SYNC_SECOND: sync2_r   <= cfg_wdata;
        CFG_MAX_LENGTH:  max_len_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    flen_nxt  = flen_r;
    bcnt_nxt  = bcnt_r;
    xor_nxt   = xor_r;
    if (in_fire) begin
      case (phase_r)
        PH_SYNC1: begin
          if (in_byte == sync1_r) phase_nxt = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (in_byte == sync2_r) begin
            phase_nxt = PH_LENGTH;
          end else if (in_byte != sync1_r) begin
            phase_nxt = PH_SYNC1;
          end
        end
        PH_LENGTH: begin
          if (len_bad) begin
            phase_nxt = PH_SYNC1;
          end else begin
            flen_nxt  = in_byte[LEN_W-1:0];
            bcnt_nxt  = '0;
            xor_nxt   = in_byte;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          bcnt_nxt = bcnt_inc;
          xor_nxt  = xor_r ^ in_byte;
          if (bcnt_inc >= flen_r) phase_nxt = PH_CHECK;
        end
        default: phase_nxt = PH_SYNC1;
      endcase
    end
  end

  always_comb begin
    evt.single = 1'b0;
    evt.start  = 1'b0;
    evt.status = ST_IDLE;
    evt.len    = flen_r;
    ram_we     = 1'b0;
    ram_waddr  = bcnt_r[ADDR_W-1:0];
    ram_wdata  = in_byte;
    case (phase_r)
      PH_LENGTH: begin
        evt.single = in_fire;
        if (len_bad) evt.status = ST_BADLEN;
      end
      PH_DATA: begin
        evt.single = in_fire;
        ram_we     = in_fire && (bcnt_r < LEN_W'(STORE_BYTES));
      end
      PH_CHECK: begin
        if (sum_ok) begin
          evt.start  = in_fire;
        end else begin
          evt.single = in_fire;
          evt.status = ST_BADSUM;
        end
      end
      default: evt.single = in_fire;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      flen_r  <= '0;
      bcnt_r  <= '0;
      xor_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      flen_r  <= flen_nxt;
      bcnt_r  <= bcnt_nxt;
      xor_r   <= xor_nxt;
    end
  end

endmodule

// File: rtl/core/slxd_replay.sv
`timescale 1ns / 1ps
module slxd_replay (
  input  logic                          clk,
  input  logic                          rst_n,
  input  slxd_pkg::evt_t                evt,
  output logic                          ready,
  output logic                          ram_re,
  output logic [slxd_pkg::ADDR_W-1:0]   ram_raddr,
  input  logic [slxd_pkg::BYTE_W-1:0]   ram_rdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,
  output logic [1:0]                    out_tuser,
  output logic                          out_tlast
);
  import slxd_pkg::*;

  logic              busy_r, busy_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_last_r, pend_last_nxt;

  logic              ov_r, ov_nxt;
  status_t           ost_r, ost_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;

  logic              o_free;
  logic              issue;
  logic              drain;

  assign o_free = !ov_r || out_tready;
  assign issue  = busy_r && (cnt_r < len_r) && (!pend_r || o_free);
  assign drain  = pend_r && o_free;
  assign ready  = !busy_r && o_free;

  assign ram_re    = issue;
  assign ram_raddr = cnt_r[ADDR_W-1:0];

  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    if (evt.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      len_nxt  = evt.len;
    end else begin
      if (issue) begin
        cnt_nxt       = cnt_r + LEN_W'(1);
        pend_last_nxt = ((cnt_r + LEN_W'(1)) == len_r);
      end
      if (issue) begin
        pend_nxt = 1'b1;
      end else if (drain) begin
        pend_nxt = 1'b0;
      end
      if (drain && pend_last_r) busy_nxt = 1'b0;
    end
  end

  always_comb begin
    ov_nxt    = ov_r;
    ost_nxt   = ost_r;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    if (drain) begin
      ov_nxt    = 1'b1;
      ost_nxt   = ST_PACKET;
      obyte_nxt = ram_rdata;
      olast_nxt = pend_last_r;
    end else if (evt.single) begin
      ov_nxt    = 1'b1;
      ost_nxt   = evt.status;
      obyte_nxt = '0;
      olast_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    len_r       <= len_nxt;
    pend_last_r <= pend_last_nxt;
    ost_r       <= ost_nxt;
    obyte_r     <= obyte_nxt;
    olast_r     <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ost_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;

endmodule

// File: rtl/core/sync_length_xor_deframer_core.sv
`timescale 1ns / 1ps
// A byte that gives one status result puts it on the output in the cycle after its transfer.
// A good checksum starts a replay from the payload memory: the first packet byte passes
// busy_r, rdata_r and ov_r in turn, then one byte per cycle while out_tready is high.
// Header and payload bytes are taken one per cycle while the output is free; input stalls
// during a replay, as the single read port of the payload memory serves one byte a cycle.
// Synchronous active-low reset restores the parser and replay flags; memory is not cleared.
module sync_length_xor_deframer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] payload_byte
  output logic [1:0] out_tuser,  // [1:0] status
  output logic       out_tlast
);
  import slxd_pkg::*;

  evt_t              evt;
  logic              in_fire;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  assign in_fire = in_tvalid && in_tready;

  slxd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .evt       (evt),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  slxd_ram #(
    .DEPTH (STORE_BYTES),
    .WIDTH (BYTE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  slxd_replay u_replay (
    .clk        (clk),
    .rst_n      (rst_n),
    .evt        (evt),
    .ready      (in_tready),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/core/slxd_checker.sv
`timescale 1ns / 1ps
module slxd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);
  import slxd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled output transfer changed");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_PACKET) |-> out_tlast)
    else $error("status result without tlast");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_PACKET) |-> (out_tdata == 8'd0))
    else $error("status result with nonzero data");

  a_replay_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_PACKET) && !out_tlast |-> !in_tready)
    else $error("input taken during a packet run");

endmodule

bind sync_length_xor_deframer_core slxd_checker u_slxd_checker (.*);
